/* design/fsfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow sensor frame checker package
// Frame layout, status codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package fsfc_pkg;

   localparam int FRAME_LEN        = 11;
   localparam int SUM_LEN          = 10;
   localparam int POS_BITS         = 4;
   localparam int ERROR_COUNT_BITS = 16;

   localparam logic [7:0] HDR0 = 8'h55;
   localparam logic [7:0] HDR1 = 8'h03;
   localparam logic [7:0] HDR2 = 8'd11;

   localparam int LEVEL_HI_POS  = 3;
   localparam int LEVEL_LO_POS  = 4;
   localparam int VOLUME_HI_POS = 5;
   localparam int VOLUME_LO_POS = 6;
   localparam int WARNING_POS   = 7;
   localparam int MODE_POS      = 8;
   localparam int INVALID_POS   = 9;
   localparam int SUM_POS       = 10;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_HEADER   = 2'd1,
      STATUS_INVALID  = 2'd2,
      STATUS_CHECKSUM = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_RESOLVE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sum_status_type;

endpackage

/* design/fsfc_sum_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame checksum unit
// Steps through frame positions 0 to 9, one byte a cycle, through one 8-bit
// adder, and holds the wrapped sum.
// ----------------------------------------------------------------------------
module fsfc_sum_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [7:0]                     byte_value,
   output logic [fsfc_pkg::POS_BITS-1:0]  index,
   output logic [7:0]                     sum,
   output fsfc_pkg::sum_status_type       status
);

   localparam logic [fsfc_pkg::POS_BITS-1:0] LAST_IDX =
      fsfc_pkg::POS_BITS'(fsfc_pkg::SUM_LEN - 1);

   logic [fsfc_pkg::POS_BITS-1:0] idx_ff, idx_in;
   logic [7:0]                    acc_ff, acc_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   always_comb begin
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         idx_in  = '0;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + byte_value;
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + fsfc_pkg::POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      acc_ff <= acc_in;
   end

   assign index       = idx_ff;
   assign sum         = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("checksum done without a pass");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> idx_ff == LAST_IDX)
      else $error("checksum pass ended early");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("checksum started while busy");

endmodule

/* design/flow_sensor_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow sensor frame checker
// Collects received link bytes in an 11-byte frame store and checks the frame
// at the end of each burst.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one received byte per beat with req_end_of_burst marking
//   the last byte of a burst. With the enable register clear every beat is
//   taken and dropped. Bytes past the eleventh of a burst are dropped.
//   rsp_ channel: one beat per enabled end of burst, with the status, the
//   values latched from the last good frame and the wrapping counters.
//   csr_ channel: writes the enable bit; always ready.
// Sequence: an end-of-burst byte is stored, then the checksum pass runs through
//   the 8-bit adder of the checksum unit, the finished sum passes to the
//   sequencer and the status is resolved; the result is registered when the
//   resolve state fires. req_ready is low meanwhile.
// Stall: a waiting result does not block byte intake; a new check waits in
//   its resolve cycle until the output register is free.
// Reset: clears the frame store, write position, latches, counters, enable
//   and the output valid flag; the output data registers are not reset.
// ----------------------------------------------------------------------------
module flow_sensor_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_burst,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_level_hundredths,
   output logic [15:0] rsp_volume_hundredths,
   output logic [7:0]  rsp_warning_code,
   output logic [7:0]  rsp_mode_code,
   output logic [7:0]  rsp_good_frames,
   output logic [15:0] rsp_header_errors,
   output logic [15:0] rsp_invalid_errors,
   output logic [15:0] rsp_checksum_errors,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_enable
);

   localparam int EB = fsfc_pkg::ERROR_COUNT_BITS;
   localparam int PB = fsfc_pkg::POS_BITS;
   localparam logic [PB-1:0] FRAME_END = PB'(fsfc_pkg::FRAME_LEN);

   fsfc_pkg::state_type state_ff, state_in;

   logic                enable_ff;
   logic [7:0]          store_ff [fsfc_pkg::FRAME_LEN];
   logic [PB-1:0]       write_pos_ff, write_pos_in;
   logic [15:0]         level_ff, level_in;
   logic [15:0]         volume_ff, volume_in;
   logic [7:0]          warning_ff, warning_in;
   logic [7:0]          mode_ff, mode_in;
   logic [7:0]          good_count_ff, good_count_in;
   logic [EB-1:0]       header_count_ff, header_count_in;
   logic [EB-1:0]       invalid_count_ff, invalid_count_in;
   logic [EB-1:0]       checksum_count_ff, checksum_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   fsfc_pkg::status_type rsp_status_ff, status_in;
   logic [15:0]         rsp_level_ff, rsp_volume_ff;
   logic [7:0]          rsp_warning_ff, rsp_mode_ff, rsp_good_ff;
   logic [15:0]         rsp_header_ff, rsp_invalid_ff, rsp_checksum_ff;

   logic                req_fire;
   logic                store_write;
   logic                sum_start;
   logic                out_free;
   logic                resolve_fire;
   logic [PB-1:0]       sum_index;
   logic [7:0]          sum_value;
   fsfc_pkg::sum_status_type sum_status;

   assign req_fire     = req_valid && req_ready;
   assign store_write  = req_fire && enable_ff && (write_pos_ff < FRAME_END);
   assign sum_start    = req_fire && enable_ff && req_end_of_burst;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign resolve_fire = (state_ff == fsfc_pkg::ST_RESOLVE) && out_free;

   fsfc_sum_unit u_sum (
      .clock      (clock),
      .reset      (reset),
      .start      (sum_start),
      .byte_value (store_ff[sum_index]),
      .index      (sum_index),
      .sum        (sum_value),
      .status     (sum_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsfc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      write_pos_in      = write_pos_ff;
      level_in          = level_ff;
      volume_in         = volume_ff;
      warning_in        = warning_ff;
      mode_in           = mode_ff;
      good_count_in     = good_count_ff;
      header_count_in   = header_count_ff;
      invalid_count_in  = invalid_count_ff;
      checksum_count_in = checksum_count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      status_in         = fsfc_pkg::STATUS_GOOD;

      if (store_ff[0] != fsfc_pkg::HDR0 || store_ff[1] != fsfc_pkg::HDR1 ||
          store_ff[2] != fsfc_pkg::HDR2) begin
         status_in = fsfc_pkg::STATUS_HEADER;
      end else if (store_ff[fsfc_pkg::INVALID_POS] != 8'd0) begin
         status_in = fsfc_pkg::STATUS_INVALID;
      end else if (sum_value != store_ff[fsfc_pkg::SUM_POS]) begin
         status_in = fsfc_pkg::STATUS_CHECKSUM;
      end

      case (state_ff)
         fsfc_pkg::ST_IDLE: begin
            if (store_write) begin
               write_pos_in = write_pos_ff + PB'(1);
            end
            if (sum_start) begin
               write_pos_in = '0;
               state_in     = fsfc_pkg::ST_SUM;
            end
         end
         fsfc_pkg::ST_SUM: begin
            if (sum_status.done) begin
               state_in = fsfc_pkg::ST_RESOLVE;
            end
         end
         fsfc_pkg::ST_RESOLVE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = fsfc_pkg::ST_IDLE;
               case (status_in)
                  fsfc_pkg::STATUS_HEADER:   header_count_in   = header_count_ff + EB'(1);
                  fsfc_pkg::STATUS_INVALID:  invalid_count_in  = invalid_count_ff + EB'(1);
                  fsfc_pkg::STATUS_CHECKSUM: checksum_count_in = checksum_count_ff + EB'(1);
                  default: begin
                     level_in      = {store_ff[fsfc_pkg::LEVEL_HI_POS],
                                      store_ff[fsfc_pkg::LEVEL_LO_POS]};
                     volume_in     = {store_ff[fsfc_pkg::VOLUME_HI_POS],
                                      store_ff[fsfc_pkg::VOLUME_LO_POS]};
                     warning_in    = store_ff[fsfc_pkg::WARNING_POS];
                     mode_in       = store_ff[fsfc_pkg::MODE_POS];
                     good_count_in = good_count_ff + 8'd1;
                  end
               endcase
            end
         end
         default: begin
            state_in = fsfc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         write_pos_ff      <= '0;
         level_ff          <= '0;
         volume_ff         <= '0;
         warning_ff        <= '0;
         mode_ff           <= '0;
         good_count_ff     <= '0;
         header_count_ff   <= '0;
         invalid_count_ff  <= '0;
         checksum_count_ff <= '0;
         rsp_valid_ff      <= 1'b0;
         for (int i = 0; i < fsfc_pkg::FRAME_LEN; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_enable;
         end
         if (store_write) begin
            store_ff[write_pos_ff] <= req_rx_byte;
         end
         write_pos_ff      <= write_pos_in;
         level_ff          <= level_in;
         volume_ff         <= volume_in;
         warning_ff        <= warning_in;
         mode_ff           <= mode_in;
         good_count_ff     <= good_count_in;
         header_count_ff   <= header_count_in;
         invalid_count_ff  <= invalid_count_in;
         checksum_count_ff <= checksum_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (resolve_fire) begin
         rsp_status_ff   <= status_in;
         rsp_level_ff    <= level_in;
         rsp_volume_ff   <= volume_in;
         rsp_warning_ff  <= warning_in;
         rsp_mode_ff     <= mode_in;
         rsp_good_ff     <= good_count_in;
         rsp_header_ff   <= 16'(header_count_in);
         rsp_invalid_ff  <= 16'(invalid_count_in);
         rsp_checksum_ff <= 16'(checksum_count_in);
      end
   end

   assign req_ready             = (state_ff == fsfc_pkg::ST_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_level_hundredths  = rsp_level_ff;
   assign rsp_volume_hundredths = rsp_volume_ff;
   assign rsp_warning_code      = rsp_warning_ff;
   assign rsp_mode_code         = rsp_mode_ff;
   assign rsp_good_frames       = rsp_good_ff;
   assign rsp_header_errors     = rsp_header_ff;
   assign rsp_invalid_errors    = rsp_invalid_ff;
   assign rsp_checksum_errors   = rsp_checksum_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      write_pos_ff <= FRAME_END)
      else $error("write position beyond frame");

   a_burst_starts_check: assert property (@(posedge clock) disable iff (reset)
      sum_start |=> state_ff == fsfc_pkg::ST_SUM && write_pos_ff == '0
                    && sum_status.busy)
      else $error("end of burst did not start a check");

   a_resolve_loads_output: assert property (@(posedge clock) disable iff (reset)
      resolve_fire |=> rsp_valid_ff && state_ff == fsfc_pkg::ST_IDLE)
      else $error("resolved check gave no result");

   a_good_counted: assert property (@(posedge clock) disable iff (reset)
      resolve_fire && status_in == fsfc_pkg::STATUS_GOOD
      |=> good_count_ff == $past(good_count_ff) + 8'd1)
      else $error("good frame not counted");

   a_done_in_sum: assert property (@(posedge clock) disable iff (reset)
      sum_status.done |-> state_ff == fsfc_pkg::ST_SUM)
      else $error("checksum finished outside a check");

endmodule

/* test/flow_sensor_frame_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow sensor frame checker testbench
// Streams link bytes into the checker in random bursts and checks every
// status beat against a frame predictor kept in step with the accepted bytes.
// Runs with reception disabled, directed frames at the field extremes, a burst
// split by a disable, and random frames: good ones, broken headers, set
// invalid-data bytes, bad checksums, short and long bursts, and noise.
// ----------------------------------------------------------------------------
module flow_sensor_frame_checker_tb;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 24;

   typedef logic [7:0] frame_type [fsfc_pkg::FRAME_LEN];

   typedef struct {
      logic [7:0] rx_byte;
      logic       end_of_burst;
   } link_byte_type;

   typedef struct {
      fsfc_pkg::status_type status;
      logic [15:0] level;
      logic [15:0] volume;
      logic [7:0]  warning;
      logic [7:0]  mode;
      logic [7:0]  good;
      logic [15:0] header_errs;
      logic [15:0] invalid_errs;
      logic [15:0] checksum_errs;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_end_of_burst = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_level_hundredths;
   logic [15:0] rsp_volume_hundredths;
   logic [7:0]  rsp_warning_code;
   logic [7:0]  rsp_mode_code;
   logic [7:0]  rsp_good_frames;
   logic [15:0] rsp_header_errors;
   logic [15:0] rsp_invalid_errors;
   logic [15:0] rsp_checksum_errors;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_enable = 1'b0;

   link_byte_type byte_backlog[$];
   reading_type   pending_readings[$];
   link_byte_type next_beat;

   // frame predictor state
   logic                                  shadow_enable = 1'b0;
   frame_type                             shadow_store = '{default: 8'h00};
   logic [fsfc_pkg::POS_BITS-1:0]         shadow_pos = '0;
   logic [15:0]                           shadow_level = '0;
   logic [15:0]                           shadow_volume = '0;
   logic [7:0]                            shadow_warning = '0;
   logic [7:0]                            shadow_mode = '0;
   logic [7:0]                            shadow_good = '0;
   logic [fsfc_pkg::ERROR_COUNT_BITS-1:0] shadow_header_errs = '0;
   logic [fsfc_pkg::ERROR_COUNT_BITS-1:0] shadow_invalid_errs = '0;
   logic [fsfc_pkg::ERROR_COUNT_BITS-1:0] shadow_checksum_errs = '0;

   int gap_left = 0;
   int burst_left = 1;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [3:0]  stall_phase = '0;

   int mismatches = 0;
   int cycle_count = 0;
   int bytes_taken = 0;
   int enable_writes = 0;
   int frames_by_status [4] = '{default: 0};

   flow_sensor_frame_checker dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .req_end_of_burst      (req_end_of_burst),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_level_hundredths  (rsp_level_hundredths),
      .rsp_volume_hundredths (rsp_volume_hundredths),
      .rsp_warning_code      (rsp_warning_code),
      .rsp_mode_code         (rsp_mode_code),
      .rsp_good_frames       (rsp_good_frames),
      .rsp_header_errors     (rsp_header_errors),
      .rsp_invalid_errors    (rsp_invalid_errors),
      .rsp_checksum_errors   (rsp_checksum_errors),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_enable            (csr_enable)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] byte_sum(input frame_type f);
      logic [7:0] sum;
      sum = 8'h00;
      for (int i = 0; i < fsfc_pkg::SUM_LEN; i++) sum = sum + f[i];
      return sum;
   endfunction

   task automatic absorb_byte(input logic [7:0] rx, input logic last);
      reading_type r;
      if (!shadow_enable) return;
      if (shadow_pos < fsfc_pkg::FRAME_LEN) begin
         shadow_store[shadow_pos] = rx;
         shadow_pos = shadow_pos + fsfc_pkg::POS_BITS'(1);
      end
      if (!last) return;
      if (shadow_store[0] != fsfc_pkg::HDR0 || shadow_store[1] != fsfc_pkg::HDR1 ||
          shadow_store[2] != fsfc_pkg::HDR2) begin
         r.status = fsfc_pkg::STATUS_HEADER;
         shadow_header_errs = shadow_header_errs + fsfc_pkg::ERROR_COUNT_BITS'(1);
      end else if (shadow_store[fsfc_pkg::INVALID_POS] != 8'h00) begin
         r.status = fsfc_pkg::STATUS_INVALID;
         shadow_invalid_errs = shadow_invalid_errs + fsfc_pkg::ERROR_COUNT_BITS'(1);
      end else if (byte_sum(shadow_store) != shadow_store[fsfc_pkg::SUM_POS]) begin
         r.status = fsfc_pkg::STATUS_CHECKSUM;
         shadow_checksum_errs = shadow_checksum_errs + fsfc_pkg::ERROR_COUNT_BITS'(1);
      end else begin
         r.status = fsfc_pkg::STATUS_GOOD;
         shadow_level   = {shadow_store[fsfc_pkg::LEVEL_HI_POS],
                           shadow_store[fsfc_pkg::LEVEL_LO_POS]};
         shadow_volume  = {shadow_store[fsfc_pkg::VOLUME_HI_POS],
                           shadow_store[fsfc_pkg::VOLUME_LO_POS]};
         shadow_warning = shadow_store[fsfc_pkg::WARNING_POS];
         shadow_mode    = shadow_store[fsfc_pkg::MODE_POS];
         shadow_good    = shadow_good + 8'd1;
      end
      shadow_pos = '0;
      r.level         = shadow_level;
      r.volume        = shadow_volume;
      r.warning       = shadow_warning;
      r.mode          = shadow_mode;
      r.good          = shadow_good;
      r.header_errs   = 16'(shadow_header_errs);
      r.invalid_errs  = 16'(shadow_invalid_errs);
      r.checksum_errs = 16'(shadow_checksum_errs);
      pending_readings.push_back(r);
   endtask

   function automatic void check_field(input string label, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatches++;
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] rx, input logic last);
      link_byte_type b;
      b.rx_byte = rx;
      b.end_of_burst = last;
      byte_backlog.push_back(b);
   endfunction

   // push len bytes of the frame, then extra random bytes; flag the final one
   function automatic int queue_burst(input frame_type f, input int len, input int extra);
      int total;
      total = len + extra;
      for (int i = 0; i < total; i++)
         queue_byte((i < len) ? f[i] : 8'($urandom), i == total - 1);
      return total;
   endfunction

   function automatic frame_type build_frame();
      frame_type f;
      f[0] = fsfc_pkg::HDR0;
      f[1] = fsfc_pkg::HDR1;
      f[2] = fsfc_pkg::HDR2;
      for (int i = fsfc_pkg::LEVEL_HI_POS; i <= fsfc_pkg::MODE_POS; i++) begin
         case ($urandom_range(0, 7))
            0: f[i] = 8'h00;
            1: f[i] = 8'hFF;
            default: f[i] = 8'($urandom);
         endcase
      end
      f[fsfc_pkg::INVALID_POS] = 8'h00;
      f[fsfc_pkg::SUM_POS] = byte_sum(f);
      return f;
   endfunction

   function automatic int queue_random_frame();
      frame_type f;
      int pick;
      int len;
      int extra;
      int n;
      f = build_frame();
      pick = $urandom_range(0, 99);
      len = fsfc_pkg::FRAME_LEN;
      extra = 0;
      if (pick < 40) begin
         len = fsfc_pkg::FRAME_LEN;
      end else if (pick < 52) begin
         f[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
      end else if (pick < 62) begin
         f[fsfc_pkg::INVALID_POS] = 8'($urandom_range(1, 255));
         if ($urandom_range(0, 1)) f[fsfc_pkg::SUM_POS] = byte_sum(f);
      end else if (pick < 72) begin
         f[fsfc_pkg::SUM_POS] ^= 8'($urandom_range(1, 255));
      end else if (pick < 82) begin
         len = $urandom_range(1, fsfc_pkg::SUM_LEN);
      end else if (pick < 92) begin
         extra = $urandom_range(1, 4);
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
         return n;
      end
      return queue_burst(f, len, extra);
   endfunction

   task automatic run_random(input int target);
      int sent;
      sent = 0;
      while (sent < target) sent += queue_random_frame();
   endtask

   // hold until every byte is taken and every status beat has come back
   task automatic settle();
      do @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || pending_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_enable(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_enable <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      enable_writes++;
   endtask

   // sender: bursts of beats with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (byte_backlog.size() != 0) begin
            next_beat = byte_backlog.pop_front();
            req_valid <= 1'b1;
            req_rx_byte <= next_beat.rx_byte;
            req_end_of_burst <= next_beat.end_of_burst;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall on a random pattern reloaded whenever the stall phase wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_phase == 4'hF) begin
            case ($urandom_range(0, 3))
               0: stall_pattern <= 16'hFFFF;
               1: stall_pattern <= 16'($urandom);
               2: stall_pattern <= 16'($urandom | $urandom);
               default: stall_pattern <= 16'($urandom & $urandom);
            endcase
         end
         stall_phase <= stall_phase + 4'd1;
         rsp_ready <= stall_pattern[stall_phase];
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) shadow_enable = csr_enable;
         if (req_valid && req_ready) begin
            bytes_taken++;
            absorb_byte(req_rx_byte, req_end_of_burst);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               $display("%0t: status beat with nothing expected, expected none, actual status %0d",
                        $time, rsp_status);
               mismatches++;
            end else begin
               want = pending_readings.pop_front();
               frames_by_status[want.status]++;
               check_field("status", want.status, rsp_status);
               check_field("level", want.level, rsp_level_hundredths);
               check_field("volume", want.volume, rsp_volume_hundredths);
               check_field("warning", want.warning, rsp_warning_code);
               check_field("mode", want.mode, rsp_mode_code);
               check_field("good frames", want.good, rsp_good_frames);
               check_field("header errors", want.header_errs, rsp_header_errors);
               check_field("invalid errors", want.invalid_errs, rsp_invalid_errors);
               check_field("checksum errors", want.checksum_errs, rsp_checksum_errors);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("flow_sensor_frame_checker test failed");
         $finish;
      end
   end

   initial begin
      frame_type f;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // disabled: every byte dropped
      set_enable(1'b0);
      for (int i = 0; i < 12; i++) queue_byte(8'($urandom), $urandom_range(0, 2) == 0);
      queue_byte(8'hFF, 1'b1);
      settle();

      set_enable(1'b1);
      f = '{fsfc_pkg::HDR0, fsfc_pkg::HDR1, fsfc_pkg::HDR2, 8'hFF, 8'hFF, 8'h00, 8'h00,
            8'hFF, 8'h00, 8'h00, 8'h00};
      f[fsfc_pkg::SUM_POS] = byte_sum(f);
      void'(queue_burst(f, fsfc_pkg::FRAME_LEN, 0));
      // one-byte burst over the stale frame: header broken at the first byte
      f[0] = 8'h00;
      void'(queue_burst(f, 1, 0));
      // long burst: trailing bytes must be dropped
      f = '{fsfc_pkg::HDR0, fsfc_pkg::HDR1, fsfc_pkg::HDR2, 8'h00, 8'h00, 8'hFF, 8'hFF,
            8'h00, 8'hFF, 8'h00, 8'h00};
      f[fsfc_pkg::SUM_POS] = byte_sum(f);
      void'(queue_burst(f, fsfc_pkg::FRAME_LEN, 2));
      settle();

      run_random(600);
      settle();

      // split a good frame across a disabled spell
      f = build_frame();
      for (int i = 0; i < 6; i++) queue_byte(f[i], 1'b0);
      settle();
      set_enable(1'b0);
      for (int i = 0; i < 8; i++) queue_byte(8'($urandom), $urandom_range(0, 1));
      settle();
      set_enable(1'b1);
      for (int i = 6; i < fsfc_pkg::FRAME_LEN; i++)
         queue_byte(f[i], i == fsfc_pkg::FRAME_LEN - 1);
      settle();

      run_random(600);
      settle();
      set_enable(1'b0);
      set_enable(1'b1);
      run_random(500);
      settle();

      $display("Run took %0d bytes over %0d enable writes; checked %0d good frames,",
               bytes_taken, enable_writes, frames_by_status[fsfc_pkg::STATUS_GOOD]);
      $display("%0d header, %0d invalid-data and %0d checksum failures",
               frames_by_status[fsfc_pkg::STATUS_HEADER],
               frames_by_status[fsfc_pkg::STATUS_INVALID],
               frames_by_status[fsfc_pkg::STATUS_CHECKSUM]);
      if (mismatches == 0)
         $display("flow_sensor_frame_checker test passed");
      else
         $display("flow_sensor_frame_checker test failed");
      $finish;
   end

endmodule

/* filelist.f */
design/fsfc_pkg.sv
design/fsfc_sum_unit.sv
design/flow_sensor_frame_checker.sv
test/flow_sensor_frame_checker_tb.sv
